// ----- rtl/core/wtod_pkg.sv -----
// Package for the detuned wavetable oscillator.
// Holds widths, codes, the sequencer state type and the shared multiplier request.
// Used by every file in rtl/core; depends on nothing.
`default_nettype none

package wtod_pkg;

   // Table geometry (power-of-two depth, index wraps by truncation)
   localparam int IDX_W         = 6;
   localparam int TABLE_DEPTH   = 2 ** IDX_W;
   localparam int FRACTION_BITS = 10;

   // Field widths
   localparam int ACT_W   = 2;
   localparam int TIDX_W  = 6;
   localparam int SAMP_W  = 16;
   localparam int MPH_W   = 16;
   localparam int DPH_W   = 17;
   localparam int LOOK_W  = DPH_W + 1;
   localparam int VOL_W   = 8;
   localparam int MODE_W  = 2;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 17;

   // Datapath widths
   localparam int DIFF_W  = SAMP_W + 1;
   localparam int PRE_W   = SAMP_W + 1;
   localparam int AMP_W   = VOL_W + 1;
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int Q1_W    = 16;

   // Divide by 3072 = 1024 * 3: shift by 10, then reciprocal of 3
   localparam int DIV_SHIFT   = 10;
   localparam int RECIP_SHIFT = 17;
   localparam logic [MUL_B_W-1:0] RECIP3 = MUL_B_W'(43691);

   // Register indexes
   localparam logic [CSR_A_W-1:0] CSR_PHASE_INC  = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_DETUNE_INC = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_VOLUME     = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_MODE       = 2'd3;

   // Detune mode that doubles the lookup phase
   localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_GEN   = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RM0,
      ST_RM1,
      ST_RD0,
      ST_RD1,
      ST_MIXM,
      ST_MULD,
      ST_DSUM,
      ST_MULA,
      ST_ABS,
      ST_MULR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                      en;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

`default_nettype wire

// ----- rtl/core/wtod_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on wtod_pkg for operand widths and the request struct.
`default_nettype none

module wtod_mul (
   input  wire logic                                clock,
   input  wire wtod_pkg::mul_req_type               mul_req,
   output logic signed [wtod_pkg::PROD_W-1:0]       mul_prod
);

   logic signed [wtod_pkg::PROD_W-1:0] prod_ff;

   // Product register, loaded only when a step issues a multiply
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= wtod_pkg::PROD_W'(mul_req.a) * wtod_pkg::PROD_W'(mul_req.b);
      end
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

// ----- rtl/core/wavetable_oscillator_detune_top.sv -----
// Detuned wavetable oscillator: two phase accumulators reading one
// 64-entry signed table with linear interpolation, mixed and scaled.
// Channels: req_* in (valid/ready), rsp_* out (valid/ready), csr_* writes.
// A write-table or load-phase beat is taken without leaving idle and gives no result.
// A generate beat runs an 11-step sequencer: four table reads through one
// registered read port, then four passes through one shared multiplier
// (main interpolation, detune interpolation, volume scale, divide by 3).
// A new generate is not taken until the sequencer has finished the last
// one and returned to idle, since it steps through one shared multiplier.
// req_ready is high only while the sequencer is idle. A finished sample sits
// in the output register; the block keeps accepting beats meanwhile and only
// holds in its last step if a second sample finishes before the first is taken.
// Reset (synchronous) clears the config registers, both phases, rsp_valid,
// the sequencer and table valid bits; the table reads as zero until written.
// Users must write configuration only while no generate is in flight; not enforced.
`default_nettype none

module wavetable_oscillator_detune_top #(
   parameter int FRACTION_BITS = wtod_pkg::FRACTION_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [wtod_pkg::ACT_W-1:0]         req_action,
   input  wire logic [wtod_pkg::TIDX_W-1:0]        req_table_index,
   input  wire logic signed [wtod_pkg::SAMP_W-1:0] req_table_value,
   input  wire logic [wtod_pkg::MPH_W-1:0]         req_main_phase_load,
   input  wire logic [wtod_pkg::DPH_W-1:0]         req_detune_phase_load,
   input  wire logic                               req_chunk_start,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [wtod_pkg::SAMP_W-1:0]      rsp_sample,
   // configuration writes
   input  wire logic                               csr_wr_en,
   input  wire logic [wtod_pkg::CSR_A_W-1:0]       csr_index,
   input  wire logic [wtod_pkg::CSR_D_W-1:0]       csr_wdata
);

   localparam int SAMP_W  = wtod_pkg::SAMP_W;
   localparam int DIFF_W  = wtod_pkg::DIFF_W;
   localparam int PRE_W   = wtod_pkg::PRE_W;
   localparam int LOOK_W  = wtod_pkg::LOOK_W;
   localparam int IDX_W   = wtod_pkg::IDX_W;
   localparam int MUL_A_W = wtod_pkg::MUL_A_W;
   localparam int MUL_B_W = wtod_pkg::MUL_B_W;
   localparam int PROD_W  = wtod_pkg::PROD_W;
   localparam int Q1_W    = wtod_pkg::Q1_W;
   localparam int AMP_W   = wtod_pkg::AMP_W;
   localparam int RECIP_SHIFT_L = wtod_pkg::RECIP_SHIFT;

   // Sequencer and phase state
   wtod_pkg::state_type state_ff, state_in;
   logic [wtod_pkg::MPH_W-1:0] mp_ff, mp_in;
   logic [wtod_pkg::DPH_W-1:0] dp_ff, dp_in;

   // Configuration registers
   logic [wtod_pkg::MPH_W-1:0]  inc_ff;
   logic [wtod_pkg::DPH_W-1:0]  dinc_ff;
   logic [wtod_pkg::VOL_W-1:0]  vol_ff;
   logic [wtod_pkg::MODE_W-1:0] mode_ff;

   // Wavetable and its valid bits
   logic [SAMP_W-1:0]            tbl_mem [wtod_pkg::TABLE_DEPTH];
   logic [wtod_pkg::TABLE_DEPTH-1:0] tv_ff, tv_in;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [IDX_W-1:0]             rd_addr;
   logic [SAMP_W-1:0]            rd_data_ff;
   logic                         rd_ok_ff;
   logic signed [SAMP_W-1:0]     rd_word;

   // Datapath registers
   logic signed [SAMP_W-1:0] am_ff, am_in;
   logic signed [SAMP_W-1:0] ad_ff, ad_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [SAMP_W-1:0] m_ff, m_in;
   logic signed [PRE_W-1:0]  pre_ff, pre_in;
   logic                     neg_ff, neg_in;
   logic [Q1_W-1:0]          q1_ff, q1_in;

   // Output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SAMP_W-1:0] rsp_sample_ff, rsp_sample_in;

   // Shared multiplier
   wtod_pkg::mul_req_type       mul_req;
   logic signed [PROD_W-1:0]    mul_prod;

   // Lookup phases, indexes and fractions
   logic [LOOK_W-1:0]        main_ext, look_ext, main_sh, look_sh;
   logic [IDX_W-1:0]         idx_m, idx_d;
   logic [MUL_B_W-1:0]       frac_m, frac_d;
   logic [AMP_W-1:0]         amp;

   // Interpolation, mix and scale terms
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [DIFF_W-1:0] interp_sum;
   logic signed [PRE_W-1:0]  d_adj;
   logic signed [PRE_W-1:0]  d_half;
   logic signed [PROD_W-1:0] prod_mag;
   logic [SAMP_W-1:0]        quot;
   logic                     req_fire;

   wtod_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   // Phase-derived lookup terms
   always_comb begin
      main_ext = LOOK_W'(mp_ff);
      look_ext = (mode_ff == wtod_pkg::MODE_DOUBLE) ? {dp_ff, 1'b0} : LOOK_W'(dp_ff);
      main_sh  = main_ext >> FRACTION_BITS;
      look_sh  = look_ext >> FRACTION_BITS;
      idx_m    = main_sh[IDX_W-1:0];
      idx_d    = look_sh[IDX_W-1:0];
      frac_m   = {{(MUL_B_W-FRACTION_BITS){1'b0}}, main_ext[FRACTION_BITS-1:0]};
      frac_d   = {{(MUL_B_W-FRACTION_BITS){1'b0}}, look_ext[FRACTION_BITS-1:0]};
      amp      = AMP_W'(vol_ff) + AMP_W'(vol_ff >> 1);
   end

   // Never-written entries read as zero
   assign rd_word = rd_ok_ff ? rd_data_ff : '0;

   // Arithmetic helpers feeding the step registers
   always_comb begin
      prod_sh    = mul_prod >>> FRACTION_BITS;
      interp_sum = DIFF_W'(state_ff == wtod_pkg::ST_MIXM ? am_ff : ad_ff)
                   + prod_sh[DIFF_W-1:0];
      // halve toward zero: add one before the shift when negative
      d_adj      = PRE_W'(signed'(interp_sum[SAMP_W-1:0]))
                   + PRE_W'({1'b0, interp_sum[SAMP_W-1]});
      d_half     = d_adj >>> 1;
      prod_mag   = mul_prod[PROD_W-1] ? -mul_prod : mul_prod;
      quot       = mul_prod[RECIP_SHIFT_L +: SAMP_W];
   end

   assign req_ready = (state_ff == wtod_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Sequencer: next state, datapath loads and multiplier requests
   always_comb begin
      state_in      = state_ff;
      mp_in         = mp_ff;
      dp_in         = dp_ff;
      tv_in         = tv_ff;
      wr_en         = 1'b0;
      wr_addr       = req_table_index[IDX_W-1:0];
      rd_addr       = idx_m;
      am_in         = am_ff;
      ad_in         = ad_ff;
      diff_in       = diff_ff;
      m_in          = m_ff;
      pre_in        = pre_ff;
      neg_in        = neg_ff;
      q1_in         = q1_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      mul_req       = '0;

      unique case (state_ff)
         wtod_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_action)
                  wtod_pkg::ACT_WRITE: begin
                     wr_en          = 1'b1;
                     tv_in[wr_addr] = 1'b1;
                  end
                  wtod_pkg::ACT_LOAD: begin
                     mp_in = req_main_phase_load;
                     dp_in = req_detune_phase_load;
                  end
                  wtod_pkg::ACT_GEN: begin
                     // resync the detune voice at a chunk start when both increments match
                     if (req_chunk_start && (wtod_pkg::DPH_W'(inc_ff) == dinc_ff)) begin
                        dp_in = wtod_pkg::DPH_W'(mp_ff);
                     end
                     state_in = wtod_pkg::ST_RM0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         wtod_pkg::ST_RM0: begin
            rd_addr  = idx_m;
            state_in = wtod_pkg::ST_RM1;
         end
         wtod_pkg::ST_RM1: begin
            rd_addr  = idx_m + IDX_W'(1);
            am_in    = rd_word;
            state_in = wtod_pkg::ST_RD0;
         end
         wtod_pkg::ST_RD0: begin
            rd_addr  = idx_d;
            diff_in  = DIFF_W'(rd_word) - DIFF_W'(am_ff);
            state_in = wtod_pkg::ST_RD1;
         end
         wtod_pkg::ST_RD1: begin
            rd_addr   = idx_d + IDX_W'(1);
            ad_in     = rd_word;
            mul_req.en = 1'b1;
            mul_req.a = MUL_A_W'(diff_ff);
            mul_req.b = frac_m;
            state_in  = wtod_pkg::ST_MIXM;
         end
         wtod_pkg::ST_MIXM: begin
            m_in     = interp_sum[SAMP_W-1:0];
            diff_in  = DIFF_W'(rd_word) - DIFF_W'(ad_ff);
            state_in = wtod_pkg::ST_MULD;
         end
         wtod_pkg::ST_MULD: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(diff_ff);
            mul_req.b  = frac_d;
            state_in   = wtod_pkg::ST_DSUM;
         end
         wtod_pkg::ST_DSUM: begin
            pre_in   = PRE_W'(m_ff) + d_half;
            state_in = wtod_pkg::ST_MULA;
         end
         wtod_pkg::ST_MULA: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(pre_ff);
            mul_req.b  = MUL_B_W'(amp);
            state_in   = wtod_pkg::ST_ABS;
         end
         wtod_pkg::ST_ABS: begin
            neg_in   = mul_prod[PROD_W-1];
            q1_in    = prod_mag[wtod_pkg::DIV_SHIFT +: Q1_W];
            state_in = wtod_pkg::ST_MULR;
         end
         wtod_pkg::ST_MULR: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(q1_ff);
            mul_req.b  = wtod_pkg::RECIP3;
            state_in   = wtod_pkg::ST_OUT;
         end
         wtod_pkg::ST_OUT: begin
            // hold while an earlier sample is still waiting
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = neg_ff ? -quot : quot;
               mp_in         = mp_ff + inc_ff;
               dp_in         = dp_ff + dinc_ff;
               state_in      = wtod_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wtod_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and phase registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wtod_pkg::ST_IDLE;
         mp_ff        <= '0;
         dp_ff        <= '0;
         tv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mp_ff        <= mp_in;
         dp_ff        <= dp_in;
         tv_ff        <= tv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff  <= '0;
         dinc_ff <= '0;
         vol_ff  <= '0;
         mode_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            wtod_pkg::CSR_PHASE_INC:  inc_ff  <= csr_wdata[wtod_pkg::MPH_W-1:0];
            wtod_pkg::CSR_DETUNE_INC: dinc_ff <= csr_wdata[wtod_pkg::DPH_W-1:0];
            wtod_pkg::CSR_VOLUME:     vol_ff  <= csr_wdata[wtod_pkg::VOL_W-1:0];
            wtod_pkg::CSR_MODE:       mode_ff <= csr_wdata[wtod_pkg::MODE_W-1:0];
         endcase
      end
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= req_table_value;
      end
      rd_data_ff <= tbl_mem[rd_addr];
      rd_ok_ff   <= tv_ff[rd_addr];
   end

   // Datapath step registers
   always_ff @(posedge clock) begin
      am_ff         <= am_in;
      ad_ff         <= ad_in;
      diff_ff       <= diff_in;
      m_ff          <= m_in;
      pre_ff        <= pre_in;
      neg_ff        <= neg_in;
      q1_ff         <= q1_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

`default_nettype wire

// ----- rtl/core/wtod_chk.sv -----
// Port-level checker for the detuned wavetable oscillator, with its bind.
// Depends on wtod_pkg for the action codes.
`default_nettype none

module wtod_chk (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic [wtod_pkg::ACT_W-1:0]  req_action,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [wtod_pkg::SAMP_W-1:0] rsp_sample
);

   // A stalled sample beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("rsp beat changed while stalled");

   // Reset leaves no sample pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // A generate beat makes the block busy
   a_gen_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == wtod_pkg::ACT_GEN) |=> !req_ready)
      else $error("ready stayed high after generate");

   // Table writes and phase loads give no sample
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action != wtod_pkg::ACT_GEN) && !rsp_valid
      |=> !rsp_valid)
      else $error("sample produced without generate");

   // A new sample only follows a busy cycle
   a_rise_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("sample appeared while idle");

endmodule

bind wavetable_oscillator_detune_top wtod_chk u_wtod_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_action (req_action),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sample (rsp_sample)
);

`default_nettype wire
